// ----- hdl/mctm_pkg.sv -----
// Shared types and constants of the multi-channel timeout monitor.
package mctm_pkg;

    localparam int OP_W       = 3;
    localparam int CH_FIELD_W = 4;
    localparam int TMO_W      = 16;
    localparam int ELAPSED_W  = 17;
    localparam int CFG_IDX_W  = 2;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_REFRESH = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_TMO = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd5;
    localparam logic [OP_W-1:0] OP_START   = 3'd6;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL  = 2'd1;

    localparam logic [TMO_W-1:0]     DEFAULT_TIMEOUT_RST = 16'd5000;
    localparam logic [TMO_W-1:0]     CHECK_INTERVAL_RST  = 16'd1000;
    localparam logic [TMO_W-1:0]     FALLBACK_INTERVAL   = 16'd1000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX         = 17'd65536;

    typedef struct packed {
        logic                 el_we;
        logic                 lim_we;
        logic [ELAPSED_W-1:0] el_wdata;
        logic [TMO_W-1:0]     lim_wdata;
    } tbl_wr_t;

endpackage

// ----- hdl/mctm_table.sv -----
// Per-channel elapsed count and timeout limit memories with one registered read port.
module mctm_table #(
    parameter int CHANNELS = 16,
    parameter int CH_W     = 4
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic [CH_W-1:0]                  rd_addr,
    input  logic [CH_W-1:0]                  wr_addr,
    input  mctm_pkg::tbl_wr_t                wr,
    output logic [mctm_pkg::ELAPSED_W-1:0]   el_rdata,
    output logic [mctm_pkg::TMO_W-1:0]       lim_rdata
);

    logic [mctm_pkg::ELAPSED_W-1:0] el_mem  [CHANNELS];
    logic [mctm_pkg::TMO_W-1:0]     lim_mem [CHANNELS];

    always_ff @(posedge aclk) begin
        if (wr.el_we) begin
            el_mem[wr_addr] <= wr.el_wdata;
        end
        if (wr.lim_we) begin
            lim_mem[wr_addr] <= wr.lim_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            el_rdata  <= el_mem[rd_addr];
            lim_rdata <= lim_mem[rd_addr];
        end
    end

endmodule

// ----- hdl/mctm_alu.sv -----
// Shared saturating incrementer and timeout comparator used once per channel of a walk.
module mctm_alu (
    input  logic                           scan,
    input  logic                           valid,
    input  logic                           tripped,
    input  logic [mctm_pkg::ELAPSED_W-1:0] elapsed,
    input  logic [mctm_pkg::TMO_W-1:0]     limit,
    output logic [mctm_pkg::ELAPSED_W-1:0] elapsed_new,
    output logic                           expired
);

    always_comb begin
        if (valid && (elapsed < mctm_pkg::ELAPSED_MAX)) begin
            elapsed_new = elapsed + 17'd1;
        end else begin
            elapsed_new = elapsed;
        end
        expired = scan && valid && !tripped
                  && (elapsed_new > {1'b0, limit});
    end

endmodule

// ----- hdl/multi_channel_timeout_monitor_unit.sv -----
// Top level of the multi-channel timeout monitor: sequencer, channel flags and result register.
// A table operation is executed in the op state, then answered from the response state.
// A tick walks every channel through one shared unit, a read state then an execute state
// per channel, and the walk stalls while a held result transaction blocks a timeout event.
// One item is processed at a time; s_ready is high only when the sequencer is idle.
// Synchronous active-low reset empties the table, stops the monitor and restores the
// register defaults; counts and limits are rewritten whenever a channel is registered.
module multi_channel_timeout_monitor_unit #(
    parameter int CHANNELS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mctm_pkg::OP_W-1:0]        s_op,
    input  logic [mctm_pkg::CH_FIELD_W-1:0]  s_channel,
    input  logic [mctm_pkg::TMO_W-1:0]       s_timeout_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_kind,
    output logic [mctm_pkg::CH_FIELD_W-1:0]  m_channel_res,
    output logic                             m_flag,
    output logic                             m_last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mctm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mctm_pkg::TMO_W-1:0]       cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(CHANNELS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_OP    = 3'd1;
    localparam logic [2:0] ST_RESP  = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_EX    = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0]                          state_reg, state_next;
    logic [mctm_pkg::OP_W-1:0]           op_reg, op_next;
    logic [mctm_pkg::CH_FIELD_W-1:0]     chan_reg, chan_next;
    logic [CH_W-1:0]                     ch_idx_reg, ch_idx_next;
    logic                                inside_reg, inside_next;
    logic [mctm_pkg::TMO_W-1:0]          tmo_reg, tmo_next;
    logic                                flag_reg, flag_next;
    logic                                scan_reg, scan_next;
    logic [CH_W-1:0]                     idx_reg, idx_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic [CH_W-1:0]                     pend_ch_reg, pend_ch_next;
    logic [CHANNELS-1:0]                 entry_valid_reg, entry_valid_next;
    logic [CHANNELS-1:0]                 tripped_reg, tripped_next;
    logic                                running_reg, running_next;
    logic [mctm_pkg::TMO_W-1:0]          ic_reg, ic_next;
    logic [mctm_pkg::TMO_W-1:0]          def_tmo_reg, def_tmo_next;
    logic [mctm_pkg::TMO_W-1:0]          interval_reg, interval_next;
    logic                                m_valid_reg, m_valid_next;
    logic                                m_kind_reg, m_kind_next;
    logic [mctm_pkg::CH_FIELD_W-1:0]     m_chan_reg, m_chan_next;
    logic                                m_flag_reg, m_flag_next;
    logic                                m_last_reg, m_last_next;

    logic                                s_fire;
    logic                                slot_free;
    logic [mctm_pkg::TMO_W-1:0]          period;
    logic [mctm_pkg::TMO_W:0]            ic_inc;
    logic                                rd_en;
    logic [CH_W-1:0]                     wr_addr;
    mctm_pkg::tbl_wr_t                   tbl_wr;
    logic [mctm_pkg::ELAPSED_W-1:0]      el_rdata;
    logic [mctm_pkg::TMO_W-1:0]          lim_rdata;
    logic [mctm_pkg::ELAPSED_W-1:0]      el_new;
    logic                                expired;
    logic                                cur_valid;
    logic                                cur_tripped;
    logic                                ch_valid;
    logic                                ch_tripped;

    mctm_table #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_table (
        .aclk      (aclk),
        .rd_en     (rd_en),
        .rd_addr   (idx_reg),
        .wr_addr   (wr_addr),
        .wr        (tbl_wr),
        .el_rdata  (el_rdata),
        .lim_rdata (lim_rdata)
    );

    mctm_alu u_alu (
        .scan        (scan_reg),
        .valid       (cur_valid),
        .tripped     (cur_tripped),
        .elapsed     (el_rdata),
        .limit       (lim_rdata),
        .elapsed_new (el_new),
        .expired     (expired)
    );

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_channel_res = m_chan_reg;
    assign m_flag        = m_flag_reg;
    assign m_last        = m_last_reg;
    assign slot_free     = !m_valid_reg || m_ready;
    assign period        = (interval_reg == '0) ? mctm_pkg::FALLBACK_INTERVAL : interval_reg;
    assign ic_inc        = {1'b0, ic_reg} + 17'd1;
    assign cur_valid     = entry_valid_reg[idx_reg];
    assign cur_tripped   = tripped_reg[idx_reg];
    assign ch_valid      = inside_reg && entry_valid_reg[ch_idx_reg];
    assign ch_tripped    = inside_reg && tripped_reg[ch_idx_reg];

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        chan_next        = chan_reg;
        ch_idx_next      = ch_idx_reg;
        inside_next      = inside_reg;
        tmo_next         = tmo_reg;
        flag_next        = flag_reg;
        scan_next        = scan_reg;
        idx_next         = idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_ch_next     = pend_ch_reg;
        entry_valid_next = entry_valid_reg;
        tripped_next     = tripped_reg;
        running_next     = running_reg;
        ic_next          = ic_reg;
        def_tmo_next     = def_tmo_reg;
        interval_next    = interval_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_kind_next      = m_kind_reg;
        m_chan_next      = m_chan_reg;
        m_flag_next      = m_flag_reg;
        m_last_next      = m_last_reg;
        rd_en            = 1'b0;
        wr_addr          = idx_reg;
        tbl_wr           = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    op_next     = s_op;
                    chan_next   = s_channel;
                    ch_idx_next = CH_W'(s_channel);
                    inside_next = (32'(s_channel) < CHANNELS);
                    tmo_next    = s_timeout_ms;
                    idx_next    = '0;
                    if (s_op == mctm_pkg::OP_TICK) begin
                        scan_next  = 1'b0;
                        state_next = ST_RD;
                        if (running_reg) begin
                            if (ic_inc >= {1'b0, period}) begin
                                scan_next = 1'b1;
                                ic_next   = '0;
                            end else begin
                                ic_next = ic_inc[mctm_pkg::TMO_W-1:0];
                            end
                        end
                    end else begin
                        state_next = ST_OP;
                    end
                end
            end
            ST_OP: begin
                wr_addr    = ch_idx_reg;
                flag_next  = 1'b0;
                state_next = ST_RESP;
                case (op_reg)
                    mctm_pkg::OP_REFRESH: begin
                        if (inside_reg) begin
                            if (!entry_valid_reg[ch_idx_reg]) begin
                                tbl_wr.lim_we    = 1'b1;
                                tbl_wr.lim_wdata = def_tmo_reg;
                            end
                            entry_valid_next[ch_idx_reg] = 1'b1;
                            tripped_next[ch_idx_reg]     = 1'b0;
                            tbl_wr.el_we                 = 1'b1;
                            flag_next                    = 1'b1;
                        end
                    end
                    mctm_pkg::OP_ADD: begin
                        if (inside_reg && (tmo_reg != '0)) begin
                            entry_valid_next[ch_idx_reg] = 1'b1;
                            tripped_next[ch_idx_reg]     = 1'b0;
                            tbl_wr.el_we                 = 1'b1;
                            tbl_wr.lim_we                = 1'b1;
                            tbl_wr.lim_wdata             = tmo_reg;
                            flag_next                    = 1'b1;
                        end
                    end
                    mctm_pkg::OP_REMOVE: begin
                        if (ch_valid) begin
                            entry_valid_next[ch_idx_reg] = 1'b0;
                            tripped_next[ch_idx_reg]     = 1'b0;
                            flag_next                    = 1'b1;
                        end
                    end
                    mctm_pkg::OP_SET_TMO: begin
                        if (ch_valid && (tmo_reg != '0)) begin
                            tbl_wr.lim_we    = 1'b1;
                            tbl_wr.lim_wdata = tmo_reg;
                            flag_next        = 1'b1;
                        end
                    end
                    mctm_pkg::OP_QUERY: begin
                        flag_next = ch_valid && ch_tripped;
                    end
                    mctm_pkg::OP_START: begin
                        if (!running_reg) begin
                            running_next = 1'b1;
                            ic_next      = '0;
                            flag_next    = 1'b1;
                        end
                    end
                    mctm_pkg::OP_STOP: begin
                        if (running_reg) begin
                            entry_valid_next = '0;
                            tripped_next     = '0;
                            running_next     = 1'b0;
                            ic_next          = '0;
                            flag_next        = 1'b1;
                        end
                    end
                    default: begin
                        flag_next = 1'b0;
                    end
                endcase
            end
            ST_RESP: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = 1'b1;
                    m_chan_next  = chan_reg;
                    m_flag_next  = flag_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD: begin
                rd_en      = 1'b1;
                state_next = ST_EX;
            end
            ST_EX: begin
                if (!(expired && pend_valid_reg && !slot_free)) begin
                    tbl_wr.el_we    = 1'b1;
                    tbl_wr.el_wdata = el_new;
                    if (expired) begin
                        tripped_next[idx_reg] = 1'b1;
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = 1'b0;
                            m_chan_next  = mctm_pkg::CH_FIELD_W'(pend_ch_reg);
                            m_flag_next  = 1'b1;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_ch_next    = idx_reg;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (slot_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = 1'b0;
                    m_chan_next     = mctm_pkg::CH_FIELD_W'(pend_ch_reg);
                    m_flag_next     = 1'b1;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mctm_pkg::CFG_DEFAULT_TIMEOUT: begin
                    def_tmo_next = cfg_data;
                end
                mctm_pkg::CFG_CHECK_INTERVAL: begin
                    interval_next = cfg_data;
                    ic_next       = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pend_valid_reg  <= 1'b0;
            entry_valid_reg <= '0;
            tripped_reg     <= '0;
            running_reg     <= 1'b0;
            ic_reg          <= '0;
            def_tmo_reg     <= mctm_pkg::DEFAULT_TIMEOUT_RST;
            interval_reg    <= mctm_pkg::CHECK_INTERVAL_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pend_valid_reg  <= pend_valid_next;
            entry_valid_reg <= entry_valid_next;
            tripped_reg     <= tripped_next;
            running_reg     <= running_next;
            ic_reg          <= ic_next;
            def_tmo_reg     <= def_tmo_next;
            interval_reg    <= interval_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        chan_reg    <= chan_next;
        ch_idx_reg  <= ch_idx_next;
        inside_reg  <= inside_next;
        tmo_reg     <= tmo_next;
        flag_reg    <= flag_next;
        scan_reg    <= scan_next;
        idx_reg     <= idx_next;
        pend_ch_reg <= pend_ch_next;
        m_kind_reg  <= m_kind_next;
        m_chan_reg  <= m_chan_next;
        m_flag_reg  <= m_flag_next;
        m_last_reg  <= m_last_next;
    end

endmodule

// ----- hdl/mctm_checker.sv -----
// Port-level checker of the multi-channel timeout monitor and its bind to the top level.
module mctm_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_kind,
    input logic [mctm_pkg::CH_FIELD_W-1:0]  m_channel_res,
    input logic                             m_flag,
    input logic                             m_last
);

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready stayed high after an accepted transaction");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_channel_res)
                                   && $stable(m_flag) && $stable(m_last)))
        else $error("stalled result transaction changed or was dropped");

    a_response_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind) |-> m_last)
        else $error("operation response not marked as final");

    a_event_flag_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_kind) |-> m_flag)
        else $error("timeout event without its flag");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind multi_channel_timeout_monitor_unit mctm_checker u_mctm_checker (.*);
